/* hw/rtl/bb3_pkg.sv */
package bb3_pkg;

  // Input kinds carried on s_tuser.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Configuration register indexes.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd800;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd600;
  localparam logic [CFG_DATA_W-1:0] MIN_DIM      = 11'd2;
  localparam logic [CFG_DATA_W-1:0] ROW_LIMIT    = 11'd1024;

  localparam logic [7:0] ALPHA_FIXED = 8'hFF;

  // floor(s * 7282 / 2^16) equals floor(s / 9) for every s below 32768.
  localparam int SUM_W     = 12;
  localparam int DIV9_W    = 13;
  localparam int PROD_W    = SUM_W + DIV9_W;
  localparam logic [DIV9_W-1:0] DIV9_MUL = 13'd7282;
  localparam int DIV9_SHIFT = 16;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = 4;

  // Output queue.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sum_t;

  typedef struct packed {
    logic       last;
    logic [9:0] row;
    logic [9:0] column;
  } tag_t;

  // Per-item control handed from the front end to the window stage.
  typedef struct packed {
    logic       have;
    logic [2:0] rmask;
    logic [2:0] cmask;
    tag_t       tag;
  } ctl_t;

  typedef struct packed {
    tag_t       tag;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } entry_t;

endpackage

/* hw/rtl/bb3_win.sv */
module bb3_win (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  bb3_pkg::pix_t top,
  input  bb3_pkg::pix_t mid,
  input  bb3_pkg::pix_t pix,
  input  bb3_pkg::ctl_t ctl,
  output logic          out_valid,
  output bb3_pkg::sum_t out_sum,
  output bb3_pkg::tag_t out_tag
);

  bb3_pkg::pix_t win      [9];
  bb3_pkg::pix_t win_next [9];
  bb3_pkg::sum_t sum;

  // Columns shift left; the newest column comes from the two line reads and the pixel.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]     = win[r*3+1];
      win_next[r*3+1]   = win[r*3+2];
    end
    win_next[2] = top;
    win_next[5] = mid;
    win_next[8] = pix;
  end

  // Neighbours outside the frame are masked off and count as zero.
  always_comb begin
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (ctl.rmask[r] && ctl.cmask[c]) begin
          sum.red   = sum.red   + bb3_pkg::SUM_W'(win_next[r*3+c].red);
          sum.green = sum.green + bb3_pkg::SUM_W'(win_next[r*3+c].green);
          sum.blue  = sum.blue  + bb3_pkg::SUM_W'(win_next[r*3+c].blue);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (in_valid) begin
        for (int i = 0; i < 9; i++) begin
          win[i] <= win_next[i];
        end
      end
      out_valid <= in_valid && ctl.have;
    end
  end

  always_ff @(posedge clk) begin
    out_sum <= sum;
    out_tag <= ctl.tag;
  end

endmodule

/* hw/rtl/bb3_outq.sv */
module bb3_outq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  bb3_pkg::sum_t                      in_sum,
  input  bb3_pkg::tag_t                      in_tag,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bb3_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                               m_tlast,
  output logic [bb3_pkg::QCW-1:0]            count
);

  bb3_pkg::entry_t            q [bb3_pkg::QDEPTH];
  bb3_pkg::entry_t            entry;
  bb3_pkg::entry_t            head;
  logic [bb3_pkg::PROD_W-1:0] prod_r;
  logic [bb3_pkg::PROD_W-1:0] prod_g;
  logic [bb3_pkg::PROD_W-1:0] prod_b;
  logic [bb3_pkg::QAW-1:0]    wptr;
  logic [bb3_pkg::QAW-1:0]    rptr;
  logic                       push;
  logic                       pop;

  // Divide by nine as a multiply by the scaled reciprocal.
  assign prod_r = bb3_pkg::PROD_W'(in_sum.red)   * bb3_pkg::PROD_W'(bb3_pkg::DIV9_MUL);
  assign prod_g = bb3_pkg::PROD_W'(in_sum.green) * bb3_pkg::PROD_W'(bb3_pkg::DIV9_MUL);
  assign prod_b = bb3_pkg::PROD_W'(in_sum.blue)  * bb3_pkg::PROD_W'(bb3_pkg::DIV9_MUL);

  always_comb begin
    entry.tag   = in_tag;
    entry.red   = prod_r[bb3_pkg::DIV9_SHIFT +: 8];
    entry.green = prod_g[bb3_pkg::DIV9_SHIFT +: 8];
    entry.blue  = prod_b[bb3_pkg::DIV9_SHIFT +: 8];
  end

  assign push     = in_valid;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign head     = q[rptr];
  assign m_tdata  = {{bb3_pkg::OUT_PAD_W{1'b0}}, head.tag.row, head.tag.column,
                     bb3_pkg::ALPHA_FIXED, head.blue, head.green, head.red};
  assign m_tlast  = head.tag.last;

  // The front end admits an item only while a slot is reserved for it.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + bb3_pkg::QCW'(push) - bb3_pkg::QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= entry;
    end
  end

endmodule

/* hw/rtl/box_blur_3x3_rgb_core.sv */
// Channel  | Direction | Transfer carries
// s_*      | in        | one pixel or drain item (tdata = red, green, blue; tuser = opcode)
// m_*      | out       | one blurred pixel (tdata = channels, alpha, column, row; tlast = EOF)
// cfg_*    | in        | register write (index 0 frame_width, 1 frame_height)
//
// One item per clock while s_tready is high; a result follows its last contributing
// item through the input registers, window stage and queue to m_*. The line stores
// are read on acceptance and written back in the next cycle, one entry per item, so
// one port pair sets the rate. A four-entry output queue with credit counting sets
// how far m_tready may stall before s_tready drops. Reset clears counters, window
// and queue; the line stores are not cleared. cfg_ready is always high.
module box_blur_3x3_rgb_core #(
  parameter int MAX_LINE = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bb3_pkg::IN_DATA_W-1:0]     s_tdata,   // in_red, in_green, in_blue
  input  logic                              s_tuser,   // opcode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bb3_pkg::OUT_DATA_W-1:0]    m_tdata,   // out_red, out_green, out_blue,
                                                       // out_alpha, out_column, out_row
  output logic                              m_tlast,   // end_of_frame
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_LINE);
  localparam int LW = (CW + 2 > 12) ? CW + 2 : 12;

  logic [bb3_pkg::CFG_DATA_W-1:0] frame_width;
  logic [bb3_pkg::CFG_DATA_W-1:0] frame_height;
  logic [LW-1:0]                  w_lim;
  logic [LW-1:0]                  h_lim;

  logic [CW-1:0] in_col;
  logic [10:0]   in_row;
  logic [CW-1:0] out_col;
  logic [9:0]    out_row;
  logic [CW-1:0] in_col_next;
  logic [10:0]   in_row_next;
  logic [CW-1:0] out_col_next;
  logic [9:0]    out_row_next;

  logic          accept;
  logic          have;
  logic          last;
  bb3_pkg::pix_t pix;
  bb3_pkg::ctl_t ctl;

  bb3_pkg::pix_t upper_mem  [MAX_LINE];
  bb3_pkg::pix_t middle_mem [MAX_LINE];
  bb3_pkg::pix_t up_rd;
  bb3_pkg::pix_t md_rd;

  logic          v1;
  logic [CW-1:0] idx1;
  bb3_pkg::pix_t pix1;
  bb3_pkg::ctl_t ctl1;

  logic                   v2;
  bb3_pkg::sum_t          sum2;
  bb3_pkg::tag_t          tag2;
  logic [bb3_pkg::QCW-1:0] q_count;
  logic [bb3_pkg::QCW-1:0] pending;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::WIDTH_RESET;
      frame_height <= bb3_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == bb3_pkg::REG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end else begin
        frame_height <= cfg_data;
      end
    end
  end

  // Registers outside the supported range are saturated where they are used.
  always_comb begin
    priority if (frame_width < bb3_pkg::MIN_DIM) begin
      w_lim = LW'(bb3_pkg::MIN_DIM);
    end else if (LW'(frame_width) > LW'(MAX_LINE)) begin
      w_lim = LW'(MAX_LINE);
    end else begin
      w_lim = LW'(frame_width);
    end
    priority if (frame_height < bb3_pkg::MIN_DIM) begin
      h_lim = LW'(bb3_pkg::MIN_DIM);
    end else if (frame_height > bb3_pkg::ROW_LIMIT) begin
      h_lim = LW'(bb3_pkg::ROW_LIMIT);
    end else begin
      h_lim = LW'(frame_height);
    end
  end

  assign pending  = bb3_pkg::QCW'(v1 && ctl1.have) + bb3_pkg::QCW'(v2) + q_count;
  assign s_tready = (pending < bb3_pkg::QCW'(bb3_pkg::QDEPTH));
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (s_tuser == bb3_pkg::OP_DRAIN) begin
      pix = '0;
    end else begin
      pix.red   = s_tdata[7:0];
      pix.green = s_tdata[15:8];
      pix.blue  = s_tdata[23:16];
    end
  end

  // Counters and masks for the item being accepted.
  always_comb begin
    have = (in_row >= 11'd2) || ((in_row == 11'd1) && (in_col != '0));
    last = (LW'(in_row) >= h_lim + 1'b1);

    ctl.have       = have;
    ctl.tag.last   = last;
    ctl.tag.row    = out_row;
    ctl.tag.column = 10'(out_col);
    ctl.rmask[0]   = (out_row != '0) && (LW'(out_row) <= h_lim);
    ctl.rmask[1]   = (LW'(out_row) < h_lim);
    ctl.rmask[2]   = (LW'(out_row) + 1'b1 < h_lim);
    ctl.cmask[0]   = (out_col != '0) && (LW'(out_col) <= w_lim);
    ctl.cmask[1]   = (LW'(out_col) < w_lim);
    ctl.cmask[2]   = (LW'(out_col) + 1'b1 < w_lim);

    out_col_next = out_col;
    out_row_next = out_row;
    if (have) begin
      if (LW'(out_col) + 1'b1 >= w_lim) begin
        out_col_next = '0;
        out_row_next = out_row + 1'b1;
      end else begin
        out_col_next = out_col + 1'b1;
      end
    end

    priority if (last) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (LW'(in_col) + 1'b1 >= w_lim) begin
      in_col_next = '0;
      in_row_next = in_row + 1'b1;
    end else begin
      in_col_next = in_col + 1'b1;
      in_row_next = in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      v1      <= 1'b0;
    end else begin
      if (accept) begin
        in_col  <= in_col_next;
        in_row  <= in_row_next;
        out_col <= out_col_next;
        out_row <= out_row_next;
      end
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx1 <= in_col;
      pix1 <= pix;
      ctl1 <= ctl;
    end
  end

  // Each entry is read when its item is accepted and rewritten the next cycle; the
  // next item always addresses a different column, except right after the frame end,
  // where the stale entry only feeds masked rows.
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd <= upper_mem[in_col];
    end
    if (v1) begin
      upper_mem[idx1] <= md_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      md_rd <= middle_mem[in_col];
    end
    if (v1) begin
      middle_mem[idx1] <= pix1;
    end
  end

  bb3_win u_win (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .top       (up_rd),
    .mid       (md_rd),
    .pix       (pix1),
    .ctl       (ctl1),
    .out_valid (v2),
    .out_sum   (sum2),
    .out_tag   (tag2)
  );

  bb3_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .in_sum   (sum2),
    .in_tag   (tag2),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .count    (q_count)
  );

endmodule

/* hw/rtl/bb3_chk.sv */
module bb3_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [bb3_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic                              m_tlast
);

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // Alpha is fixed and the padding above the row field stays zero.
  a_out_fixed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:24] == bb3_pkg::ALPHA_FIXED) &&
                 (m_tdata[bb3_pkg::OUT_DATA_W-1 -: bb3_pkg::OUT_PAD_W] == '0))
    else $error("alpha or padding wrong");

  // With the queue drained and no accepted item still in flight, input is open.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !$past(s_tvalid && s_tready) && !$past(s_tvalid && s_tready, 2) &&
    !$past(s_tvalid && s_tready, 3) |-> s_tready)
    else $error("input blocked while idle");

endmodule

bind box_blur_3x3_rgb_core bb3_chk u_bb3_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* dv/tb_box_blur_3x3_rgb_core.sv */
module tb_box_blur_3x3_rgb_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX = 1024;
  localparam int ROW_MAX = 1024;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS = 420;
  localparam int PRINT_LIMIT = 50;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [9:0] column;
    logic [9:0] row;
    logic       eof;
  } blur_px_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [bb3_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           s_tuser = bb3_pkg::OP_PIXEL;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [bb3_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic                           cfg_index = bb3_pkg::REG_FRAME_WIDTH;
  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the block's registers, line stores, window and counters.
  logic [bb3_pkg::CFG_DATA_W-1:0] geo_width_reg;
  logic [bb3_pkg::CFG_DATA_W-1:0] geo_height_reg;
  bb3_pkg::pix_t                  upper_line [LINE_MAX];
  bb3_pkg::pix_t                  middle_line [LINE_MAX];
  bb3_pkg::pix_t                  window_px [9];
  int unsigned                    in_col, in_row, out_col, out_row;
  bit                             frame_done;
  blur_px_t                       blur_expected [$];

  int mismatch_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int tx_gap_max = 5;
  int rx_gap_max = 5;
  int rx_hold = 0;
  int rx_draw;

  always #5 clk = ~clk;

  box_blur_3x3_rgb_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic reset_predictor();
    geo_width_reg = 11'd800;
    geo_height_reg = 11'd600;
    for (int k = 0; k < LINE_MAX; k++) begin
      upper_line[k] = '0;
      middle_line[k] = '0;
    end
    for (int k = 0; k < 9; k++) window_px[k] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    frame_done = 0;
  endtask

  task automatic predict_blur(input logic op, input bb3_pkg::pix_t px);
    int unsigned w, h, idx, sr, sg, sb;
    int nr, nc;
    bb3_pkg::pix_t pix, top, mid, p;
    bit have, last;
    blur_px_t res;
    w = clamp_dim(geo_width_reg, 2, LINE_MAX);
    h = clamp_dim(geo_height_reg, 2, ROW_MAX);
    pix = (op == bb3_pkg::OP_DRAIN) ? bb3_pkg::pix_t'(24'd0) : px;
    idx = (in_col < LINE_MAX) ? in_col : LINE_MAX - 1;
    top = upper_line[idx];
    mid = middle_line[idx];
    upper_line[idx] = mid;
    middle_line[idx] = pix;
    for (int i = 0; i < 3; i++) begin
      window_px[i*3] = window_px[i*3+1];
      window_px[i*3+1] = window_px[i*3+2];
    end
    window_px[2] = top;
    window_px[5] = mid;
    window_px[8] = pix;
    have = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    last = (in_row >= h + 1);
    if (have) begin
      sr = 0;
      sg = 0;
      sb = 0;
      // Window row i and column j sit i-1 lines and j-1 pixels from the result position.
      for (int i = 0; i < 3; i++) begin
        nr = int'(out_row) + i - 1;
        for (int j = 0; j < 3; j++) begin
          nc = int'(out_col) + j - 1;
          if (nr >= 0 && nr < int'(h) && nc >= 0 && nc < int'(w)) begin
            p = window_px[i*3+j];
            sr += p.red;
            sg += p.green;
            sb += p.blue;
          end
        end
      end
      res.red = 8'(sr / 9);
      res.green = 8'(sg / 9);
      res.blue = 8'(sb / 9);
      res.alpha = 8'hFF;
      res.column = 10'(out_col);
      res.row = 10'(out_row);
      res.eof = last;
      blur_expected.push_back(res);
      if (out_col + 1 >= w) begin
        out_col = 0;
        out_row = (out_row + 1) % 1024;
      end else begin
        out_col = (out_col + 1) % 1024;
      end
    end
    if (last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      frame_done = 1;
    end else if (in_col + 1 >= w) begin
      in_col = 0;
      in_row = (in_row + 1) % 2048;
    end else begin
      in_col = (in_col + 1) % 1024;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want, input blur_px_t ref_px);
    if (got !== want)
      flag_mismatch($sformatf("%s at row %0d col %0d: got %0h, expected %0h",
                              name, ref_px.row, ref_px.column, got, want));
  endtask

  task automatic check_result(input logic [bb3_pkg::OUT_DATA_W-1:0] data, input logic eof);
    blur_px_t want;
    if (blur_expected.size() == 0) begin
      flag_mismatch($sformatf("result transfer with nothing pending: %0h", data));
      return;
    end
    want = blur_expected.pop_front();
    check_field("red", 16'(data[7:0]), 16'(want.red), want);
    check_field("green", 16'(data[15:8]), 16'(want.green), want);
    check_field("blue", 16'(data[23:16]), 16'(want.blue), want);
    check_field("alpha", 16'(data[31:24]), 16'(want.alpha), want);
    check_field("column", 16'(data[41:32]), 16'(want.column), want);
    check_field("row", 16'(data[51:42]), 16'(want.row), want);
    check_field("pad", 16'(data[55:52]), 16'd0, want);
    check_field("end_of_frame", 16'(eof), 16'(want.eof), want);
  endtask

  // Result side: check every transfer, then stall for a random draw of up to rx_gap_max, which may be zero.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
    end else if (m_tvalid && m_tready) begin
      check_result(m_tdata, m_tlast);
      rx_draw = $urandom_range(rx_gap_max, 0);
      if (rx_draw > 0) begin
        m_tready <= 1'b0;
        rx_hold <= rx_draw;
      end
    end else if (!m_tready) begin
      if (rx_hold <= 1) m_tready <= 1'b1;
      else rx_hold <= rx_hold - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Valid is left high after a transfer so that back-to-back items need no toggle.
  task automatic send_pixel(input logic op, input bb3_pkg::pix_t px);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    predict_blur(op, px);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [bb3_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bb3_pkg::REG_FRAME_WIDTH) geo_width_reg = value;
    else geo_height_reg = value;
  endtask

  task automatic set_geometry(input int w, input int h);
    wait_drained();
    write_register(bb3_pkg::REG_FRAME_WIDTH, bb3_pkg::CFG_DATA_W'(w));
    write_register(bb3_pkg::REG_FRAME_HEIGHT, bb3_pkg::CFG_DATA_W'(h));
    cfg_valid <= 1'b0;
  endtask

  // Pixels inside the frame, drain items past it, with a few of each swapped in.
  task automatic stream_items(input int count, input bit to_end);
    int sent;
    int unsigned h;
    logic op;
    bb3_pkg::pix_t px;
    sent = 0;
    frame_done = 0;
    while (to_end ? !frame_done : sent < count) begin
      h = clamp_dim(geo_height_reg, 2, ROW_MAX);
      op = (in_row < h) ? bb3_pkg::OP_PIXEL : bb3_pkg::OP_DRAIN;
      if ($urandom_range(19, 0) == 0) begin
        op = (op == bb3_pkg::OP_PIXEL) ? bb3_pkg::OP_DRAIN : bb3_pkg::OP_PIXEL;
      end
      px = bb3_pkg::pix_t'(24'($urandom));
      send_pixel(op, px);
      sent++;
    end
  endtask

  // Reset geometry is 800 wide: the first result needs a full line plus two pixels.
  task automatic test_reset_geometry();
    stream_items(805, 0);
  endtask

  task automatic test_midframe_write();
    // Column counters already beyond the new width wrap on their next advance.
    set_geometry(4, 2);
    stream_items(0, 1);
    // Input row already past the new height ends the frame on the next item.
    set_geometry(3, 8);
    stream_items(18, 0);
    set_geometry(3, 2);
    stream_items(0, 1);
  endtask

  task automatic test_width_saturation();
    set_geometry(3, 4);
    stream_items(4, 0);
    set_geometry(2047, 4);
    stream_items(10, 0);
    set_geometry(3, 4);
    stream_items(0, 1);
  endtask

  task automatic test_channel_extremes();
    tx_gap_max = 0;
    rx_gap_max = 0;
    set_geometry(3, 3);
    for (int k = 0; k < 9; k++) begin
      send_pixel((k == 4) ? bb3_pkg::OP_DRAIN : bb3_pkg::OP_PIXEL,
                 bb3_pkg::pix_t'(24'hFFFFFF));
    end
    for (int k = 0; k < 4; k++) begin
      send_pixel((k == 2) ? bb3_pkg::OP_PIXEL : bb3_pkg::OP_DRAIN,
                 bb3_pkg::pix_t'(24'hFFFFFF));
    end
    set_geometry(2, 2);
    send_pixel(bb3_pkg::OP_PIXEL, bb3_pkg::pix_t'(24'h0000FF));
    send_pixel(bb3_pkg::OP_PIXEL, bb3_pkg::pix_t'(24'h00FF00));
    send_pixel(bb3_pkg::OP_PIXEL, bb3_pkg::pix_t'(24'hFF0000));
    send_pixel(bb3_pkg::OP_PIXEL, bb3_pkg::pix_t'(24'h000000));
    for (int k = 0; k < 3; k++) send_pixel(bb3_pkg::OP_DRAIN, bb3_pkg::pix_t'(24'hFFFFFF));
  endtask

  task automatic test_random_frames();
    int target, w, h;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      tx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 5;
      rx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 5;
      if ($urandom_range(1, 0) == 0) begin
        case ($urandom_range(7, 0))
          0: w = $urandom_range(1, 0);
          1: w = $urandom_range(64, 17);
          default: w = $urandom_range(12, 2);
        endcase
        h = ($urandom_range(7, 0) == 0) ? $urandom_range(1, 0) : $urandom_range(8, 2);
        set_geometry(w, h);
      end
      // Now and then a truncated frame, so the next write lands mid-frame.
      if ($urandom_range(9, 0) == 0) stream_items($urandom_range(20, 1), 0);
      else stream_items(0, 1);
    end
  endtask

  initial begin
    reset_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_geometry();
    test_midframe_write();
    test_width_saturation();
    test_channel_extremes();
    test_random_frames();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bb3_pkg.sv
hw/rtl/bb3_win.sv
hw/rtl/bb3_outq.sv
hw/rtl/box_blur_3x3_rgb_core.sv
hw/rtl/bb3_chk.sv
dv/tb_box_blur_3x3_rgb_core.sv
